/* src/htb_pkg.sv */
package htb_pkg;

  // Status codes reported on the end-of-text word
  typedef enum logic [2:0] {
    ST_OK       = 3'd0,
    ST_EMPTY    = 3'd1,
    ST_INVALID  = 3'd2,
    ST_ODD      = 3'd3,
    ST_TOO_LONG = 3'd4
  } status_t;

  // Result word kinds
  localparam logic KIND_DATA   = 1'b0;
  localparam logic KIND_STATUS = 1'b1;

  // Character codes the decoder treats specially
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_TAB   = 8'h09;
  localparam logic [7:0] CH_COLON = 8'h3A;
  localparam logic [7:0] CH_DASH  = 8'h2D;
  localparam logic [7:0] CH_UNDER = 8'h5F;
  localparam logic [7:0] CH_LOW_X = 8'h78;
  localparam logic [7:0] CH_UP_X  = 8'h58;
  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_NINE  = 8'h39;
  localparam logic [7:0] CH_LOW_A = 8'h61;
  localparam logic [7:0] CH_LOW_F = 8'h66;
  localparam logic [7:0] CH_UP_A  = 8'h41;
  localparam logic [7:0] CH_UP_F  = 8'h46;
  localparam logic [3:0] DIGIT_TEN = 4'd10;

  localparam logic [1:0] POS_SAT = 2'd2;

  // Per-text decoder state
  typedef struct packed {
    logic [3:0]  pending_nibble;
    logic        nibble_waiting;
    logic [1:0]  char_position;
    logic [15:0] decoded_total;
    status_t     error_latched;
  } dec_state_t;

  // One result word
  typedef struct packed {
    logic        result_kind;
    logic [7:0]  byte_value;
    status_t     status_code;
    logic [15:0] byte_count;
  } result_t;

endpackage

/* src/htb_step.sv */
module htb_step (
  input  htb_pkg::dec_state_t st,
  input  logic [7:0]          char_code,
  input  logic                end_of_text,
  input  logic [15:0]         byte_capacity,
  output htb_pkg::dec_state_t st_nxt,
  output logic                res_valid,
  output htb_pkg::result_t    res
);
  import htb_pkg::*;

  logic       is_sep;
  logic       is_dec;
  logic       is_low;
  logic       is_up;
  logic [3:0] digit;
  logic       is_prefix_x;

  // Classify the character
  always_comb begin
    is_sep = (char_code == CH_SPACE) || (char_code == CH_TAB) ||
             (char_code == CH_COLON) || (char_code == CH_DASH) ||
             (char_code == CH_UNDER);
    is_dec = (char_code >= CH_ZERO) && (char_code <= CH_NINE);
    is_low = (char_code >= CH_LOW_A) && (char_code <= CH_LOW_F);
    is_up  = (char_code >= CH_UP_A) && (char_code <= CH_UP_F);
    priority if (is_dec) begin
      digit = 4'(char_code - CH_ZERO);
    end else if (is_low) begin
      digit = 4'(char_code - CH_LOW_A) + DIGIT_TEN;
    end else if (is_up) begin
      digit = 4'(char_code - CH_UP_A) + DIGIT_TEN;
    end else begin
      digit = 4'd0;
    end
    // Second character x after a leading zero drops the prefix
    is_prefix_x = (st.char_position == 2'd1) &&
                  ((char_code == CH_LOW_X) || (char_code == CH_UP_X)) &&
                  st.nibble_waiting && (st.pending_nibble == 4'd0);
  end

  // Next state and result
  always_comb begin
    st_nxt          = st;
    res_valid       = 1'b0;
    res.result_kind = KIND_DATA;
    res.byte_value  = 8'd0;
    res.status_code = ST_OK;
    res.byte_count  = 16'd0;

    if (end_of_text) begin
      res_valid       = 1'b1;
      res.result_kind = KIND_STATUS;
      priority if (st.error_latched != ST_OK) begin
        res.status_code = st.error_latched;
      end else if (st.nibble_waiting) begin
        res.status_code = ST_ODD;
      end else if (st.decoded_total == 16'd0) begin
        res.status_code = ST_EMPTY;
      end else begin
        res.status_code = ST_OK;
        res.byte_count  = st.decoded_total;
      end
      // Clear for the next text
      st_nxt.pending_nibble = 4'd0;
      st_nxt.nibble_waiting = 1'b0;
      st_nxt.char_position  = 2'd0;
      st_nxt.decoded_total  = 16'd0;
      st_nxt.error_latched  = ST_OK;
    end else begin
      if (st.char_position != POS_SAT) begin
        st_nxt.char_position = st.char_position + 2'd1;
      end
      if (st.error_latched == ST_OK) begin
        priority if (is_prefix_x) begin
          st_nxt.nibble_waiting = 1'b0;
        end else if (is_sep) begin
          if (st.nibble_waiting) begin
            st_nxt.error_latched = ST_ODD;
          end
        end else if (!(is_dec || is_low || is_up)) begin
          st_nxt.error_latched = ST_INVALID;
        end else if (!st.nibble_waiting) begin
          st_nxt.pending_nibble = digit;
          st_nxt.nibble_waiting = 1'b1;
        end else if (st.decoded_total >= byte_capacity) begin
          st_nxt.error_latched = ST_TOO_LONG;
        end else begin
          // Complete the pair and emit the byte
          res_valid             = 1'b1;
          res.byte_value        = {st.pending_nibble, digit};
          st_nxt.decoded_total  = st.decoded_total + 16'd1;
          st_nxt.nibble_waiting = 1'b0;
          st_nxt.pending_nibble = 4'd0;
        end
      end
    end
  end

endmodule

/* src/hex_text_to_bytes_decoder.sv */
// Hex text to bytes decoder.
// Input channel: one character per word (in_char_code), with in_end_of_text
// marking the terminator word of a text. A word is taken at a clock edge with
// in_valid high and in_stall low. An optional leading 0x/0X is dropped, and
// space, tab, colon, dash and underscore may separate whole bytes.
// Output channel: a data word (result_kind 0) for each completed digit pair,
// and one status word (result_kind 1) per text carrying status_code and
// byte_count. A word leaves at an edge with out_valid high and out_stall low.
// After the first error the rest of the text yields nothing until the end
// word; the consumer drops any data words of that text.
// A result is registered into the output slot, or into the skid slot while
// the output slot is held. Throughput: one character per cycle while in_stall
// is low; the decode is one pass of logic between state and output registers.
// Stall: a two-word output buffer sits behind the decoder; in_stall rises
// only when both output slots hold words, so one more character is taken
// while a result waits.
// cfg_we/cfg_wdata write byte_capacity (reset 65535), applied from the next
// completed pair. Reset (rst_n low, synchronous) clears the text state and
// both output slots.
module hex_text_to_bytes_decoder (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [7:0]  in_char_code,
  input  logic        in_end_of_text,
  output logic        out_valid,
  input  logic        out_stall,
  output logic        out_result_kind,
  output logic [7:0]  out_byte_value,
  output logic [2:0]  out_status_code,
  output logic [15:0] out_byte_count,
  input  logic        cfg_we,
  input  logic [15:0] cfg_wdata
);
  import htb_pkg::*;

  logic [15:0] capacity_r;
  dec_state_t  state_r;
  dec_state_t  state_nxt;
  logic        res_valid;
  result_t     res;
  logic        in_take;
  logic        out_take;

  logic        out_valid_r;
  result_t     out_r;
  logic        skid_valid_r;
  result_t     skid_r;

  assign in_take  = in_valid && !skid_valid_r;
  assign out_take = out_valid_r && !out_stall;
  assign in_stall = skid_valid_r;

  htb_step u_step (
    .st            (state_r),
    .char_code     (in_char_code),
    .end_of_text   (in_end_of_text),
    .byte_capacity (capacity_r),
    .st_nxt        (state_nxt),
    .res_valid     (res_valid),
    .res           (res)
  );

  // Hold the capacity register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      capacity_r <= 16'hFFFF;
    end else if (cfg_we) begin
      capacity_r <= cfg_wdata;
    end
  end

  // Advance the text state on each accepted word
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r.pending_nibble <= 4'd0;
      state_r.nibble_waiting <= 1'b0;
      state_r.char_position  <= 2'd0;
      state_r.decoded_total  <= 16'd0;
      state_r.error_latched  <= ST_OK;
    end else if (in_take) begin
      state_r <= state_nxt;
    end
  end

  // Output slot and skid slot
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r  <= 1'b0;
      skid_valid_r <= 1'b0;
    end else if (skid_valid_r) begin
      if (out_take) begin
        out_valid_r  <= 1'b1;
        skid_valid_r <= 1'b0;
      end
    end else if (!out_valid_r || out_take) begin
      out_valid_r <= in_take && res_valid;
    end else if (in_take && res_valid) begin
      skid_valid_r <= 1'b1;
    end
  end

  // Payload moves without reset
  always_ff @(posedge clk) begin
    if (skid_valid_r) begin
      if (out_take) begin
        out_r <= skid_r;
      end
    end else if (!out_valid_r || out_take) begin
      if (in_take && res_valid) begin
        out_r <= res;
      end
    end else if (in_take && res_valid) begin
      skid_r <= res;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_result_kind = out_r.result_kind;
  assign out_byte_value  = out_r.byte_value;
  assign out_status_code = out_r.status_code;
  assign out_byte_count  = out_r.byte_count;

endmodule

/* src/htb_checker.sv */
module htb_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        out_valid,
  input logic        out_stall,
  input logic        out_result_kind,
  input logic [7:0]  out_byte_value,
  input logic [2:0]  out_status_code,
  input logic [15:0] out_byte_count
);
  import htb_pkg::*;

  // A stalled result word stays offered
  a_hold_valid: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid)
    else $error("result word dropped while stalled");

  // A stalled result word keeps its payload
  a_hold_data: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> $stable(out_result_kind) && $stable(out_byte_value) &&
                               $stable(out_status_code) && $stable(out_byte_count))
    else $error("result payload changed while stalled");

  // Data words carry no status and no count
  a_data_clean: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_result_kind == KIND_DATA) |->
      (out_status_code == ST_OK) && (out_byte_count == 16'd0))
    else $error("data word with status fields set");

  // A status word has a count only when ok, and an ok status has bytes
  a_status_count: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_result_kind == KIND_STATUS) |->
      (out_byte_value == 8'd0) &&
      ((out_status_code == ST_OK) == (out_byte_count != 16'd0)))
    else $error("status word count does not match status");

endmodule

bind hex_text_to_bytes_decoder htb_checker u_htb_checker (
  .clk             (clk),
  .rst_n           (rst_n),
  .out_valid       (out_valid),
  .out_stall       (out_stall),
  .out_result_kind (out_result_kind),
  .out_byte_value  (out_byte_value),
  .out_status_code (out_status_code),
  .out_byte_count  (out_byte_count)
);

/* bench/testbench.sv */
`timescale 1ns / 1ps

module testbench;
  import htb_pkg::*;

  localparam int STALL_LIMIT = 500;
  localparam int IDLE_PCT = 31;

  // Directed script rows: a character checked by the decoder model, a character
  // with a hand-written result, or a capacity write
  typedef enum logic [1:0] {ROW_CHAR, ROW_KNOWN, ROW_CAPACITY} row_kind_t;

  typedef struct packed {
    row_kind_t   kind;
    logic [15:0] capacity;
    logic [7:0]  ch;
    logic        eot;
    result_t     want;
  } script_row_t;

  // Ways a random text is damaged
  typedef enum logic [2:0] {
    FLAW_NONE, FLAW_NOISE, FLAW_SPLIT, FLAW_DROP, FLAW_STRAY_X
  } flaw_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic [7:0]  in_char_code = 8'h00;
  logic        in_end_of_text = 1'b0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic        out_result_kind;
  logic [7:0]  out_byte_value;
  logic [2:0]  out_status_code;
  logic [15:0] out_byte_count;
  logic        cfg_we = 1'b0;
  logic [15:0] cfg_wdata = 16'h0000;

  // Decoder model state
  logic [15:0] capacity = 16'hFFFF;
  logic [3:0]  pend_nib = 4'd0;
  logic        nib_wait = 1'b0;
  logic [1:0]  char_pos = 2'd0;
  logic [15:0] byte_total = 16'd0;
  status_t     err_code = ST_OK;

  result_t     awaited_words[$];
  script_row_t script[$];
  result_t     head_word;
  int          mismatches = 0;
  int          live_chars = 0;
  int          quiet_cycles = 0;
  bit          idle_on = 1'b1;

  hex_text_to_bytes_decoder dut (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .in_char_code    (in_char_code),
    .in_end_of_text  (in_end_of_text),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_result_kind (out_result_kind),
    .out_byte_value  (out_byte_value),
    .out_status_code (out_status_code),
    .out_byte_count  (out_byte_count),
    .cfg_we          (cfg_we),
    .cfg_wdata       (cfg_wdata)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // Advance the decoder model by one character; return 1 when a word comes out
  function automatic logic decode_char(input logic [7:0] c, input logic eot,
                                       output result_t word);
    logic [1:0] pos;
    logic [3:0] dig;
    logic       is_dig;
    word = '0;
    if (eot) begin
      word.result_kind = KIND_STATUS;
      if (err_code != ST_OK) word.status_code = err_code;
      else if (nib_wait) word.status_code = ST_ODD;
      else if (byte_total == 16'd0) word.status_code = ST_EMPTY;
      else begin
        word.status_code = ST_OK;
        word.byte_count = byte_total;
      end
      pend_nib = 4'd0;
      nib_wait = 1'b0;
      char_pos = 2'd0;
      byte_total = 16'd0;
      err_code = ST_OK;
      return 1'b1;
    end
    pos = char_pos;
    if (char_pos < POS_SAT) char_pos = char_pos + 2'd1;
    if (err_code != ST_OK) return 1'b0;
    // drop the 0x prefix
    if (pos == 2'd1 && (c == CH_LOW_X || c == CH_UP_X) && nib_wait && pend_nib == 4'd0) begin
      nib_wait = 1'b0;
      return 1'b0;
    end
    if (c == CH_SPACE || c == CH_TAB || c == CH_COLON || c == CH_DASH || c == CH_UNDER) begin
      if (nib_wait) err_code = ST_ODD;
      return 1'b0;
    end
    is_dig = 1'b1;
    dig = 4'd0;
    if (c >= CH_ZERO && c <= CH_NINE) dig = 4'(c - CH_ZERO);
    else if (c >= CH_LOW_A && c <= CH_LOW_F) dig = 4'(c - CH_LOW_A) + DIGIT_TEN;
    else if (c >= CH_UP_A && c <= CH_UP_F) dig = 4'(c - CH_UP_A) + DIGIT_TEN;
    else is_dig = 1'b0;
    if (!is_dig) begin
      err_code = ST_INVALID;
      return 1'b0;
    end
    if (!nib_wait) begin
      pend_nib = dig;
      nib_wait = 1'b1;
      return 1'b0;
    end
    if (byte_total >= capacity) begin
      err_code = ST_TOO_LONG;
      return 1'b0;
    end
    word.result_kind = KIND_DATA;
    word.byte_value = {pend_nib, dig};
    byte_total = byte_total + 16'd1;
    nib_wait = 1'b0;
    pend_nib = 4'd0;
    return 1'b1;
  endfunction

  function automatic logic [7:0] hex_char(input logic [3:0] n, input logic upper);
    if (n < DIGIT_TEN) return CH_ZERO + 8'(n);
    return (upper ? CH_UP_A : CH_LOW_A) + 8'(n - DIGIT_TEN);
  endfunction

  function automatic logic [7:0] pick_separator();
    case ($urandom_range(4))
      0: return CH_SPACE;
      1: return CH_TAB;
      2: return CH_COLON;
      3: return CH_DASH;
      default: return CH_UNDER;
    endcase
  endfunction

  task automatic report_mismatch(input string what, input int got, input int want);
    mismatches++;
    $display("[%0t] %s: got %0d, want %0d", $time, what, got, want);
  endtask

  // Offer one word and hold it until taken, then log what should come out
  task automatic send_word(input logic [7:0] c, input logic eot, input logic known,
                           input result_t want);
    result_t w;
    logic    got;
    if (idle_on && $urandom_range(99) < IDLE_PCT) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 3)) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_char_code <= c;
    in_end_of_text <= eot;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    if (eot || err_code == ST_OK) live_chars++;
    got = decode_char(c, eot, w);
    if (known) awaited_words.push_back(want);
    else if (got) awaited_words.push_back(w);
  endtask

  task automatic drop_input();
    in_valid <= 1'b0;
    @(posedge clk);
  endtask

  // Let the decoder drain, then write byte_capacity
  task automatic set_capacity(input logic [15:0] value);
    drop_input();
    while (awaited_words.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
    cfg_we <= 1'b1;
    cfg_wdata <= value;
    @(posedge clk);
    cfg_we <= 1'b0;
    capacity = value;
  endtask

  task automatic row_char(input logic [7:0] c, input logic eot);
    script_row_t r;
    r = '0;
    r.kind = ROW_CHAR;
    r.ch = c;
    r.eot = eot;
    script.push_back(r);
  endtask

  task automatic row_known(input logic [7:0] c, input logic eot, input logic kind,
                           input logic [7:0] value, input status_t st,
                           input logic [15:0] count);
    script_row_t r;
    r = '0;
    r.kind = ROW_KNOWN;
    r.ch = c;
    r.eot = eot;
    r.want.result_kind = kind;
    r.want.byte_value = value;
    r.want.status_code = st;
    r.want.byte_count = count;
    script.push_back(r);
  endtask

  task automatic row_capacity(input logic [15:0] value);
    script_row_t r;
    r = '0;
    r.kind = ROW_CAPACITY;
    r.capacity = value;
    script.push_back(r);
  endtask

  // Build one text, mostly well formed, sometimes damaged, and send it
  task automatic send_text();
    logic [7:0] txt[$];
    logic [7:0] b;
    int         nbytes;
    flaw_t      flaw;
    nbytes = ($urandom_range(9) == 0) ? $urandom_range(7, 20) : $urandom_range(0, 5);
    flaw = ($urandom_range(99) < 25) ? flaw_t'($urandom_range(1, 4)) : FLAW_NONE;
    if ($urandom_range(2) == 0) begin
      txt.push_back(CH_ZERO);
      txt.push_back($urandom_range(1) ? CH_LOW_X : CH_UP_X);
    end
    for (int i = 0; i < nbytes; i++) begin
      if (i > 0 && $urandom_range(99) < 40) txt.push_back(pick_separator());
      b = 8'($urandom_range(255));
      txt.push_back(hex_char(b[7:4], 1'($urandom_range(1))));
      txt.push_back(hex_char(b[3:0], 1'($urandom_range(1))));
    end
    case (flaw)
      FLAW_NOISE:   txt.insert($urandom_range(txt.size()), 8'($urandom_range(255)));
      FLAW_SPLIT:   txt.insert($urandom_range(txt.size()), pick_separator());
      FLAW_DROP:    if (txt.size() > 0) txt.delete($urandom_range(txt.size() - 1));
      FLAW_STRAY_X: txt.insert($urandom_range(txt.size()),
                               $urandom_range(1) ? CH_LOW_X : CH_UP_X);
      default: ;
    endcase
    foreach (txt[k]) send_word(txt[k], 1'b0, 1'b0, '0);
    send_word(8'($urandom_range(255)), 1'b1, 1'b0, '0);
  endtask

  // Stall the result side at random
  always @(posedge clk) begin
    out_stall <= idle_on && ($urandom_range(99) < IDLE_PCT);
  end

  // Check each word that leaves against the oldest one logged
  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) begin
      if (awaited_words.size() == 0) begin
        report_mismatch("unexpected word, kind", out_result_kind, -1);
      end else begin
        head_word = awaited_words.pop_front();
        if (out_result_kind !== head_word.result_kind)
          report_mismatch("result_kind", out_result_kind, head_word.result_kind);
        if (out_byte_value !== head_word.byte_value)
          report_mismatch("byte_value", out_byte_value, head_word.byte_value);
        if (out_status_code !== head_word.status_code)
          report_mismatch("status_code", out_status_code, head_word.status_code);
        if (out_byte_count !== head_word.byte_count)
          report_mismatch("byte_count", out_byte_count, head_word.byte_count);
      end
    end
  end

  // End the run when nothing moves for too long
  always @(posedge clk) begin
    if (rst_n) begin
      if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
        quiet_cycles <= 0;
      end else if (quiet_cycles >= STALL_LIMIT) begin
        $display("hex_text_to_bytes_decoder verification failed");
        $finish;
      end else begin
        quiet_cycles <= quiet_cycles + 1;
      end
    end
  end

  initial begin
    logic [15:0] phase_caps[7];
    int          target;
    phase_caps = '{16'hFFFF, 16'd0, 16'd2, 16'd5, 16'hFFFF, 16'd1, 16'd40};
    phase_caps[6] = 16'($urandom_range(16'hFFFF));
    target = 0;

    repeat (7) @(posedge clk);
    rst_n <= 1'b1;

    // Directed script: reset state, prefix, separators, each error, capacity
    row_known(8'h00, 1'b1, KIND_STATUS, 8'h00, ST_EMPTY, 16'd0);
    row_char(CH_ZERO, 1'b0);
    row_char(CH_UP_X, 1'b0);
    row_char("f", 1'b0);
    row_known("F", 1'b0, KIND_DATA, 8'hFF, ST_OK, 16'd0);
    row_char(CH_SPACE, 1'b0);
    row_char("9", 1'b0);
    row_char("a", 1'b0);
    row_char(CH_UNDER, 1'b0);
    row_known(8'hFF, 1'b1, KIND_STATUS, 8'h00, ST_OK, 16'd2);
    row_char(CH_ZERO, 1'b0);
    row_char(CH_LOW_X, 1'b0);
    row_known(8'h00, 1'b1, KIND_STATUS, 8'h00, ST_EMPTY, 16'd0);
    row_char("1", 1'b0);
    row_char(CH_DASH, 1'b0);
    row_known(8'h00, 1'b1, KIND_STATUS, 8'h00, ST_ODD, 16'd0);
    row_char(8'h00, 1'b0);
    row_known(8'h00, 1'b1, KIND_STATUS, 8'h00, ST_INVALID, 16'd0);
    row_char("5", 1'b0);
    row_known(8'h00, 1'b1, KIND_STATUS, 8'h00, ST_ODD, 16'd0);
    row_capacity(16'd0);
    row_char(CH_ZERO, 1'b0);
    row_char(CH_ZERO, 1'b0);
    row_known(8'h00, 1'b1, KIND_STATUS, 8'h00, ST_TOO_LONG, 16'd0);
    row_capacity(16'd1);
    row_char("a", 1'b0);
    row_known("B", 1'b0, KIND_DATA, 8'hAB, ST_OK, 16'd0);
    // raise the capacity mid-text: one more pair fits
    row_capacity(16'd2);
    row_char("c", 1'b0);
    row_char("D", 1'b0);
    row_char("e", 1'b0);
    row_char("f", 1'b0);
    row_known(8'h00, 1'b1, KIND_STATUS, 8'h00, ST_TOO_LONG, 16'd0);
    row_capacity(16'hFFFF);

    foreach (script[i]) begin
      if (script[i].kind == ROW_CAPACITY) set_capacity(script[i].capacity);
      else send_word(script[i].ch, script[i].eot, script[i].kind == ROW_KNOWN,
                     script[i].want);
    end

    // Random texts in phases of different capacity; one phase never idles
    live_chars = 0;
    for (int p = 0; p < 7; p++) begin
      set_capacity(phase_caps[p]);
      idle_on = (p != 4);
      target += 85;
      while (live_chars < target) send_text();
    end

    // Drain and settle
    idle_on = 1'b1;
    drop_input();
    while (awaited_words.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
    if (mismatches == 0) begin
      $display("hex_text_to_bytes_decoder verification clean");
    end else begin
      $display("hex_text_to_bytes_decoder verification failed");
    end
    $finish;
  end

endmodule
